FILE: hdl/crss_pkg.sv
// shared types and constants for the color result saturate stage
`default_nettype none

package crss_pkg;

    localparam int VALUE_W = 48;
    localparam int MAC_W   = 32;
    localparam int IR_W    = 16;
    localparam int CHAN_W  = 8;
    localparam int CODE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int FLAGS_W = 12;
    localparam int NUM_CH  = 3;
    localparam int COLOR_SHIFT = 4;

    // overflow beyond signed 44 bits looks at bits 47..43
    localparam int MAC_LIMIT_BIT = 43;
    // ir range is signed 16 bits, so bits 47..15 decide
    localparam int IR_LIMIT_BIT  = 15;

    localparam logic signed [IR_W-1:0] IR_MAX     = 16'sh7FFF;
    localparam logic signed [IR_W-1:0] IR_MIN     = -16'sh8000;
    localparam logic signed [IR_W-1:0] IR_MIN_ZERO = 16'sh0000;
    localparam logic [CHAN_W-1:0]      CHAN_MAX   = 8'hFF;
    localparam logic [CHAN_W-1:0]      CHAN_MIN   = 8'h00;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_x;
        logic signed [VALUE_W-1:0] value_y;
        logic signed [VALUE_W-1:0] value_z;
        logic                      clamp_at_zero;
        logic [CODE_W-1:0]         code_byte;
    } t_in_word;

    typedef struct packed {
        logic signed [MAC_W-1:0] mac_one;
        logic signed [MAC_W-1:0] mac_two;
        logic signed [MAC_W-1:0] mac_three;
        logic signed [IR_W-1:0]  ir_one;
        logic signed [IR_W-1:0]  ir_two;
        logic signed [IR_W-1:0]  ir_three;
        logic [WORD_W-1:0]       newest_color;
        logic [WORD_W-1:0]       middle_color;
        logic [WORD_W-1:0]       oldest_color;
        logic [FLAGS_W-1:0]      raised_flags;
    } t_out_word;

    // per component result from one saturation lane
    typedef struct packed {
        logic signed [MAC_W-1:0] mac;
        logic signed [IR_W-1:0]  ir;
        logic [CHAN_W-1:0]       chan;
        logic                    mac_pos_ovf;
        logic                    mac_neg_ovf;
        logic                    ir_clamp;
        logic                    chan_clamp;
    } t_lane_result;

endpackage

`default_nettype wire

FILE: hdl/color_result_saturate_stage.sv
// top level of the color result saturate stage
`default_nettype none

// Two-register pipeline: an input word is captured in the input register, the
// three saturation lanes and the color fifo shift run between it and the
// result register, so one word is taken every cycle while the output side is
// ready. The result word moves from the input register into the result
// register and is held there until the output side takes it. A stalled
// result holds the result register and a full input register; the input
// register still takes a word while it is empty, or while the result register
// is full but about to drain. The three-entry color fifo shifts when a word
// moves into the result register, so fifo order follows input order. The fifo
// is all zero after reset.
module color_result_saturate_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire crss_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output crss_pkg::t_out_word     o_out_word
);

    // input register
    logic                 r_in_valid;
    crss_pkg::t_in_word   r_in;

    // result register
    logic                 r_out_valid;
    crss_pkg::t_out_word  r_out;
    crss_pkg::t_out_word  n_out;

    // color fifo: 0 newest, 2 oldest
    logic [crss_pkg::WORD_W-1:0] r_fifo [crss_pkg::NUM_CH];

    crss_pkg::t_lane_result w_lane_x;
    crss_pkg::t_lane_result w_lane_y;
    crss_pkg::t_lane_result w_lane_z;

    logic w_out_free;   // result register can take a word this cycle
    logic w_load;       // input register moves into result register
    logic w_in_take;    // input handshake

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_load      = r_in_valid && w_out_free;
    assign o_in_ready  = !r_in_valid || w_out_free;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    crss_lane u_lane_x (
        .i_value         (r_in.value_x),
        .i_clamp_at_zero (r_in.clamp_at_zero),
        .o_result        (w_lane_x)
    );

    crss_lane u_lane_y (
        .i_value         (r_in.value_y),
        .i_clamp_at_zero (r_in.clamp_at_zero),
        .o_result        (w_lane_y)
    );

    crss_lane u_lane_z (
        .i_value         (r_in.value_z),
        .i_clamp_at_zero (r_in.clamp_at_zero),
        .o_result        (w_lane_z)
    );

    // assemble the result word, fifo shown after the shift
    always_comb begin
        n_out.mac_one      = w_lane_x.mac;
        n_out.mac_two      = w_lane_y.mac;
        n_out.mac_three    = w_lane_z.mac;
        n_out.ir_one       = w_lane_x.ir;
        n_out.ir_two       = w_lane_y.ir;
        n_out.ir_three     = w_lane_z.ir;
        n_out.newest_color = {r_in.code_byte, w_lane_z.chan, w_lane_y.chan, w_lane_x.chan};
        n_out.middle_color = r_fifo[0];
        n_out.oldest_color = r_fifo[1];
        n_out.raised_flags = {
            w_lane_z.chan_clamp,  w_lane_y.chan_clamp,  w_lane_x.chan_clamp,
            w_lane_z.ir_clamp,    w_lane_y.ir_clamp,    w_lane_x.ir_clamp,
            w_lane_z.mac_neg_ovf, w_lane_y.mac_neg_ovf, w_lane_x.mac_neg_ovf,
            w_lane_z.mac_pos_ovf, w_lane_y.mac_pos_ovf, w_lane_x.mac_pos_ovf
        };
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_word;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    // color fifo is state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo[0] <= '0;
            r_fifo[1] <= '0;
            r_fifo[2] <= '0;
        end else if (w_load) begin
            r_fifo[0] <= n_out.newest_color;
            r_fifo[1] <= r_fifo[0];
            r_fifo[2] <= r_fifo[1];
        end
    end

    // a held result always shows the current fifo contents
    a_fifo_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.newest_color == r_fifo[0] &&
                         r_out.middle_color == r_fifo[1] &&
                         r_out.oldest_color == r_fifo[2]))
        else $error("result word and color fifo disagree");

    // the fifo shift pushes the previous newest word into the middle slot
    a_fifo_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_fifo[1] == $past(r_fifo[0]) && r_fifo[2] == $past(r_fifo[1])))
        else $error("color fifo did not shift by one entry");

    // a component cannot overflow both ways at once
    a_ovf_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.raised_flags[2:0] & r_out.raised_flags[5:3]) == 3'b000))
        else $error("positive and negative overflow flagged together");

    // input side only stalls behind a full input register and a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

FILE: hdl/crss_lane.sv
// saturation lane for one accumulator component
`default_nettype none

module crss_lane (
    input  wire logic signed [crss_pkg::VALUE_W-1:0] i_value,
    input  wire logic                                i_clamp_at_zero,
    output crss_pkg::t_lane_result                   o_result
);

    localparam int VW = crss_pkg::VALUE_W;

    logic       w_neg;
    logic       w_mac_hi_any;
    logic       w_mac_hi_all;
    logic       w_ir_hi_any;
    logic       w_ir_hi_all;
    logic [crss_pkg::MAC_W-1:0] w_mac;

    assign w_neg        = i_value[VW-1];
    assign w_mac_hi_any = |i_value[VW-2:crss_pkg::MAC_LIMIT_BIT];
    assign w_mac_hi_all = &i_value[VW-2:crss_pkg::MAC_LIMIT_BIT];
    assign w_ir_hi_any  = |i_value[VW-2:crss_pkg::IR_LIMIT_BIT];
    assign w_ir_hi_all  = &i_value[VW-2:crss_pkg::IR_LIMIT_BIT];
    assign w_mac        = i_value[crss_pkg::MAC_W-1:0];

    always_comb begin
        o_result.mac         = w_mac;
        o_result.mac_pos_ovf = !w_neg && w_mac_hi_any;
        o_result.mac_neg_ovf = w_neg && !w_mac_hi_all;

        // ir clamp works on the full value
        if (!w_neg && w_ir_hi_any) begin
            o_result.ir       = crss_pkg::IR_MAX;
            o_result.ir_clamp = 1'b1;
        end else if (w_neg && i_clamp_at_zero) begin
            o_result.ir       = crss_pkg::IR_MIN_ZERO;
            o_result.ir_clamp = 1'b1;
        end else if (w_neg && !w_ir_hi_all) begin
            o_result.ir       = crss_pkg::IR_MIN;
            o_result.ir_clamp = 1'b1;
        end else begin
            o_result.ir       = i_value[crss_pkg::IR_W-1:0];
            o_result.ir_clamp = 1'b0;
        end

        // color channel from the truncated mac, shifted down
        if (w_mac[crss_pkg::MAC_W-1]) begin
            o_result.chan       = crss_pkg::CHAN_MIN;
            o_result.chan_clamp = 1'b1;
        end else if (|w_mac[crss_pkg::MAC_W-2:crss_pkg::COLOR_SHIFT+crss_pkg::CHAN_W]) begin
            o_result.chan       = crss_pkg::CHAN_MAX;
            o_result.chan_clamp = 1'b1;
        end else begin
            o_result.chan       =
                w_mac[crss_pkg::COLOR_SHIFT+crss_pkg::CHAN_W-1:crss_pkg::COLOR_SHIFT];
            o_result.chan_clamp = 1'b0;
        end
    end

endmodule

`default_nettype wire
